>>> design/ntars_pkg.sv
// ----------------------------------------------------------------------------
// ntars_pkg: neighbor table package
// Shared types and codes for the neighbor table with aging and ranging select.
// ----------------------------------------------------------------------------
package ntars_pkg;

	localparam int TimeW = 48;
	localparam int IdW   = 7;
	localparam int DistW = 24;

	typedef enum logic [2:0] {
		ACT_SEEN   = 3'd0,
		ACT_SWEEP  = 3'd1,
		ACT_RANGED = 3'd2,
		ACT_NEXT   = 3'd3,
		ACT_LIST   = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NOT_DUE   = 3'd4,
		ST_LIMIT     = 3'd5
	} status_t;

	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_REFRESH = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_SEEN,
		S_RANGED,
		S_SWEEP_SCAN,
		S_SWEEP_FIND,
		S_SWEEP_DROP,
		S_NEXT_SCAN,
		S_NEXT_DONE,
		S_LIST,
		S_EMIT
	} state_t;

endpackage

>>> design/neighbor_table_aging_ranging_select.sv
// ----------------------------------------------------------------------------
// neighbor_table_aging_ranging_select
// Packed neighbor table with aging sweep, ranging selection and listing.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one action per beat; m_axis returns result beats, the final
//   beat of an action flagged by tlast. Config is a plain write port (cfg_we,
//   cfg_index, cfg_data) that the user writes only while the block is idle; unenforced.
// Throughput:
//   one entry is visited per cycle by a single shared compare unit, so a
//   seen, ranged or next action scans at most fill_count entries; a sweep
//   searches each removed id again before the tail entry moves into its
//   slot; a list emits one beat per entry per cycle while m_axis_tready is
//   high. s_axis_tready is high only when no action is in progress.
// Reset:
//   arst_n clears the fill count, both registers and the sequencer; table
//   contents are not cleared and are never read above the fill count.
// Stall:
//   a result beat waits in the output register while m_axis_tready is low;
//   the sequencer holds before loading the next beat until it is taken.
// ----------------------------------------------------------------------------
module neighbor_table_aging_ranging_select
	import ntars_pkg::*;
#(
	parameter int MAX_NEIGHBORS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// action[2:0], now_time[50:3], neighbor_id[57:51], ranging_time[105:58],
	// distance_mm[129:106], list_limit[134:130], zero fill to 136
	input  logic [135:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[2:0], out_id[9:3], out_distance[33:10], entry_count[38:34]
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int CW = $clog2(MAX_NEIGHBORS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_NEIGHBORS);

	// table storage
	logic [IdW-1:0]   ids_q    [MAX_NEIGHBORS];
	logic [TimeW-1:0] seen_q   [MAX_NEIGHBORS];
	logic [TimeW-1:0] rng_q    [MAX_NEIGHBORS];
	logic [DistW-1:0] dist_q   [MAX_NEIGHBORS];
	logic [IdW-1:0]   gone_q   [MAX_NEIGHBORS];

	logic [CW-1:0]    fill_q, idx_q, ngone_q, gidx_q;
	logic [IW-1:0]    best_q;
	logic [TimeW-1:0] timeout_q, refresh_q;
	state_t           state_q, state_d;

	// latched item
	action_t          act_q;
	logic [TimeW-1:0] now_q, rtime_q;
	logic [IdW-1:0]   id_q;
	logic [DistW-1:0] dist_in_q;
	logic [4:0]       limit_q;

	// output register
	logic             ovalid_q, olast_q;
	logic [2:0]       ostat_q;
	logic [IdW-1:0]   oid_q;
	logic [DistW-1:0] odist_q;
	logic [4:0]       ocnt_q;

	logic [IW-1:0]    ix, tail_ix;
	logic [IdW-1:0]   key;
	logic             in_range, hit, out_free;
	logic [TimeW:0]   sum_a, sum_b;

	assign ix       = idx_q[IW-1:0];
	assign tail_ix  = IW'(fill_q - CW'(1));
	assign in_range = idx_q < fill_q;
	assign key      = (state_q == S_SWEEP_FIND) ? gone_q[gidx_q[IW-1:0]] : id_q;
	assign hit      = in_range && (ids_q[ix] == key);
	assign out_free = !ovalid_q || m_axis_tready;
	// shared 49-bit adder: entry time plus a register
	assign sum_a    = {1'b0, (state_q == S_SWEEP_SCAN) ? seen_q[ix] : rng_q[best_q]}
		+ {1'b0, (state_q == S_SWEEP_SCAN) ? timeout_q : refresh_q};
	assign sum_b    = {1'b0, now_q};

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tlast  = olast_q;
	assign m_axis_tdata  = {1'b0, ocnt_q, odist_q, oid_q, ostat_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					unique case (s_axis_tdata[2:0])
						ACT_SEEN, ACT_RANGED: state_d = S_FIND;
						ACT_SWEEP: state_d = S_SWEEP_SCAN;
						ACT_NEXT: state_d = S_NEXT_SCAN;
						ACT_LIST: state_d = S_LIST;
						default: state_d = S_EMIT;
					endcase
				end
			end
			S_FIND: if (hit || !in_range)
				state_d = (act_q == ACT_SEEN) ? S_SEEN : S_RANGED;
			S_SEEN, S_RANGED, S_NEXT_DONE: if (out_free) state_d = S_EMIT;
			S_SWEEP_SCAN: if (!in_range) state_d = S_SWEEP_FIND;
			S_SWEEP_FIND: begin
				if (gidx_q >= ngone_q) state_d = S_EMIT;
				else if (hit) state_d = S_SWEEP_DROP;
			end
			S_SWEEP_DROP: state_d = S_SWEEP_FIND;
			S_NEXT_SCAN: if (!in_range) state_d = S_NEXT_DONE;
			S_LIST: begin
				if (out_free && (limit_q < 5'(fill_q) || fill_q == '0
					|| idx_q + CW'(1) >= fill_q))
					state_d = S_EMIT;
			end
			S_EMIT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			timeout_q <= '0;
			refresh_q <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == REG_TIMEOUT) timeout_q <= cfg_data;
			if (cfg_we && cfg_index == REG_REFRESH) refresh_q <= cfg_data;
			if (m_axis_tready) ovalid_q <= 1'b0;
			// simple actions and sweep finish: one beat, last
			if (state_q == S_EMIT && out_free && act_q != ACT_LIST
				&& act_q != ACT_SEEN && act_q != ACT_RANGED && act_q != ACT_NEXT)
				ovalid_q <= 1'b1;
			if ((state_q == S_SEEN || state_q == S_RANGED || state_q == S_NEXT_DONE
				|| state_q == S_LIST) && out_free)
				ovalid_q <= 1'b1;
			if (state_q == S_SEEN && out_free && !(idx_q < fill_q) && fill_q < MAXC)
				fill_q <= fill_q + CW'(1);
			if (state_q == S_SWEEP_DROP) fill_q <= fill_q - CW'(1);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				act_q     <= action_t'(s_axis_tdata[2:0]);
				now_q     <= s_axis_tdata[50:3];
				id_q      <= s_axis_tdata[57:51];
				rtime_q   <= s_axis_tdata[105:58];
				dist_in_q <= s_axis_tdata[129:106];
				limit_q   <= s_axis_tdata[134:130];
				idx_q     <= '0;
				ngone_q   <= '0;
				gidx_q    <= '0;
				best_q    <= '0;
			end
			S_FIND: if (!(hit || !in_range)) idx_q <= idx_q + CW'(1);
			S_SEEN: if (out_free) begin
				olast_q <= 1'b1;
				oid_q   <= id_q;
				if (in_range) begin
					seen_q[ix] <= now_q;
					ostat_q    <= ST_OK;
					odist_q    <= dist_q[ix];
					ocnt_q     <= 5'(fill_q);
				end else if (fill_q >= MAXC) begin
					ostat_q <= ST_FULL;
					odist_q <= '0;
					ocnt_q  <= 5'(fill_q);
				end else begin
					ids_q[ix]  <= id_q;
					seen_q[ix] <= now_q;
					rng_q[ix]  <= '0;
					dist_q[ix] <= '0;
					ostat_q    <= ST_OK;
					odist_q    <= '0;
					ocnt_q     <= 5'(fill_q + CW'(1));
				end
			end
			S_RANGED: if (out_free) begin
				olast_q <= 1'b1;
				oid_q   <= id_q;
				ocnt_q  <= 5'(fill_q);
				if (in_range) begin
					rng_q[ix]  <= rtime_q;
					dist_q[ix] <= dist_in_q;
					ostat_q    <= ST_OK;
					odist_q    <= dist_in_q;
				end else begin
					ostat_q <= ST_NOT_FOUND;
					odist_q <= '0;
				end
			end
			S_SWEEP_SCAN: if (in_range) begin
				if ({1'b0, now_q} > sum_a) begin
					gone_q[ngone_q[IW-1:0]] <= ids_q[ix];
					ngone_q <= ngone_q + CW'(1);
				end
				idx_q <= idx_q + CW'(1);
			end else idx_q <= '0;
			S_SWEEP_FIND: begin
				if (hit) begin
					best_q <= ix;
				end else if (in_range) idx_q <= idx_q + CW'(1);
				else begin
					idx_q  <= '0;
					gidx_q <= gidx_q + CW'(1);
				end
			end
			S_SWEEP_DROP: begin
				ids_q[best_q]  <= ids_q[tail_ix];
				seen_q[best_q] <= seen_q[tail_ix];
				rng_q[best_q]  <= rng_q[tail_ix];
				dist_q[best_q] <= dist_q[tail_ix];
				idx_q  <= '0;
				gidx_q <= gidx_q + CW'(1);
			end
			S_NEXT_SCAN: if (in_range) begin
				if (rng_q[ix] < rng_q[best_q]) best_q <= ix;
				idx_q <= idx_q + CW'(1);
			end
			S_NEXT_DONE: if (out_free) begin
				olast_q <= 1'b1;
				ocnt_q  <= 5'(fill_q);
				if (fill_q == '0) begin
					ostat_q <= ST_EMPTY; oid_q <= '0; odist_q <= '0;
				end else if (sum_b < sum_a) begin
					ostat_q <= ST_NOT_DUE; oid_q <= '0; odist_q <= '0;
				end else begin
					ostat_q <= ST_OK; oid_q <= ids_q[best_q]; odist_q <= dist_q[best_q];
				end
			end
			S_LIST: if (out_free) begin
				ocnt_q <= 5'(fill_q);
				if (limit_q < 5'(fill_q)) begin
					ostat_q <= ST_LIMIT; oid_q <= '0; odist_q <= '0; olast_q <= 1'b1;
				end else if (fill_q == '0) begin
					ostat_q <= ST_EMPTY; oid_q <= '0; odist_q <= '0; olast_q <= 1'b1;
				end else begin
					ostat_q <= ST_OK;
					oid_q   <= ids_q[ix];
					odist_q <= dist_q[ix];
					olast_q <= (idx_q + CW'(1) >= fill_q);
					idx_q   <= idx_q + CW'(1);
				end
			end
			S_EMIT: if (out_free) begin
				ostat_q <= ST_OK; oid_q <= '0; odist_q <= '0; olast_q <= 1'b1;
				ocnt_q  <= 5'(fill_q);
			end
			default: ;
		endcase
	end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: neighbor table aging and ranging select
// Drives table actions over the input stream, predicts every result beat with
// a behavioral table model and checks the output stream field by field.
// ----------------------------------------------------------------------------
module testbench
	import ntars_pkg::*;
();

	localparam int NMAX = 16;
	localparam longint CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  id;
		logic [23:0] distance;
		logic [4:0]  count;
		logic        last;
	} beat_t;

	typedef struct {
		logic [2:0]  act;
		logic [47:0] now;
		logic [6:0]  id;
		logic [47:0] rtime;
		logic [23:0] dist_mm;
		logic [4:0]  limit;
		logic        chk;
		logic [2:0]  st;
		logic [4:0]  cnt;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic         cfg_index = 1'b0;
	logic [47:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [39:0]  m_axis_tdata;
	logic         m_axis_tlast;

	neighbor_table_aging_ranging_select dut (.*);

	always #4 clk = ~clk;

	// table model state
	logic [6:0]  t_id [NMAX];
	logic [47:0] t_seen [NMAX];
	logic [47:0] t_rng [NMAX];
	logic [23:0] t_dist [NMAX];
	int          t_fill;
	logic [47:0] m_timeout, m_refresh;

	beat_t  pending_beats[$];
	int     errors = 0;
	longint cycles = 0;
	int     send_idle = 0, recv_stall = 0, hold_off = 0;

	function automatic beat_t mk(logic [2:0] s, logic [6:0] i, logic [23:0] d, logic l);
		beat_t b;
		b.status = s; b.id = i; b.distance = d; b.count = t_fill[4:0]; b.last = l;
		return b;
	endfunction

	function automatic int find_id(logic [6:0] id);
		for (int i = 0; i < t_fill; i++)
			if (t_id[i] == id) return i;
		return -1;
	endfunction

	// predict the result beats of one action and update the model table
	task automatic predict_table(input row_t r);
		int s, b, n;
		logic [6:0] gone [NMAX];
		n = 0;
		case (r.act)
			ACT_SEEN: begin
				s = find_id(r.id);
				if (s >= 0) begin
					t_seen[s] = r.now;
					pending_beats.push_back(mk(ST_OK, r.id, t_dist[s], 1));
				end else if (t_fill >= NMAX) begin
					pending_beats.push_back(mk(ST_FULL, r.id, 0, 1));
				end else begin
					t_id[t_fill] = r.id; t_seen[t_fill] = r.now;
					t_rng[t_fill] = 0; t_dist[t_fill] = 0; t_fill++;
					pending_beats.push_back(mk(ST_OK, r.id, 0, 1));
				end
			end
			ACT_SWEEP: begin
				for (int i = 0; i < t_fill; i++)
					if ({1'b0, r.now} > {1'b0, t_seen[i]} + {1'b0, m_timeout})
						gone[n++] = t_id[i];
				for (int k = 0; k < n; k++) begin
					s = find_id(gone[k]);
					if (s >= 0) begin
						t_fill--;
						t_id[s] = t_id[t_fill]; t_seen[s] = t_seen[t_fill];
						t_rng[s] = t_rng[t_fill]; t_dist[s] = t_dist[t_fill];
					end
				end
				pending_beats.push_back(mk(ST_OK, 0, 0, 1));
			end
			ACT_RANGED: begin
				s = find_id(r.id);
				if (s < 0) pending_beats.push_back(mk(ST_NOT_FOUND, r.id, 0, 1));
				else begin
					t_rng[s] = r.rtime; t_dist[s] = r.dist_mm;
					pending_beats.push_back(mk(ST_OK, r.id, r.dist_mm, 1));
				end
			end
			ACT_NEXT: begin
				if (t_fill == 0) pending_beats.push_back(mk(ST_EMPTY, 0, 0, 1));
				else begin
					b = 0;
					for (int i = 1; i < t_fill; i++)
						if (t_rng[i] < t_rng[b]) b = i;
					if ({1'b0, r.now} < {1'b0, t_rng[b]} + {1'b0, m_refresh})
						pending_beats.push_back(mk(ST_NOT_DUE, 0, 0, 1));
					else
						pending_beats.push_back(mk(ST_OK, t_id[b], t_dist[b], 1));
				end
			end
			ACT_LIST: begin
				if (r.limit < t_fill) pending_beats.push_back(mk(ST_LIMIT, 0, 0, 1));
				else if (t_fill == 0) pending_beats.push_back(mk(ST_EMPTY, 0, 0, 1));
				else
					for (int i = 0; i < t_fill; i++)
						pending_beats.push_back(mk(ST_OK, t_id[i], t_dist[i], i + 1 == t_fill));
			end
			default: pending_beats.push_back(mk(ST_OK, 0, 0, 1));
		endcase
	endtask

	// send one action beat, waiting for acceptance; valid stays up for back to back
	task automatic send_action(input row_t r);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata <= {1'b0, r.limit, r.dist_mm, r.rtime, r.id, r.now, r.act};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_table(r);
		if (r.chk && (pending_beats[$].status != r.st || pending_beats[$].count != r.cnt)) begin
			$error("directed row: status expected %0d got %0d, count expected %0d got %0d",
				r.st, pending_beats[$].status, r.cnt, pending_beats[$].count);
			errors++;
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [47:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_TIMEOUT) m_timeout = v; else m_refresh = v;
	endtask

	function automatic row_t rnd_row(int idpool);
		row_t r;
		int p;
		p = $urandom_range(99);
		r.act = p < 35 ? ACT_SEEN : p < 48 ? ACT_SWEEP : p < 68 ? ACT_RANGED :
			p < 82 ? ACT_NEXT : p < 96 ? ACT_LIST : 3'($urandom_range(7, 5));
		r.now = 48'({$urandom(), $urandom()});
		if ($urandom_range(3) == 0) r.now = 48'($urandom_range(255));
		r.id = 7'($urandom_range(idpool - 1));
		r.rtime = 48'({$urandom(), $urandom()});
		if ($urandom_range(2) == 0) r.rtime = 48'($urandom_range(1000));
		r.dist_mm = 24'($urandom());
		r.limit = $urandom_range(3) == 0 ? 5'($urandom()) : 5'($urandom_range(16));
		r.chk = 0; r.st = 0; r.cnt = 0;
		return r;
	endfunction

	// output checker and receiver stall
	always @(posedge clk) begin
		beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_beats.size() == 0) begin
				$error("result beat with nothing expected: %h", m_axis_tdata);
				errors++;
			end else begin
				want = pending_beats.pop_front();
				if (m_axis_tdata[2:0] != want.status) begin
					$error("status expected %0d actual %0d", want.status, m_axis_tdata[2:0]); errors++; end
				if (m_axis_tdata[9:3] != want.id) begin
					$error("out_id expected %0d actual %0d", want.id, m_axis_tdata[9:3]); errors++; end
				if (m_axis_tdata[33:10] != want.distance) begin
					$error("out_distance expected %0d actual %0d", want.distance,
						m_axis_tdata[33:10]);
					errors++; end
				if (m_axis_tdata[38:34] != want.count) begin
					$error("entry_count expected %0d actual %0d", want.count, m_axis_tdata[38:34]);
					errors++; end
				if (m_axis_tlast != want.last) begin
					$error("last_result expected %0d actual %0d", want.last, m_axis_tlast); errors++; end
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	row_t dir[$];
	row_t r;

	initial begin
		t_fill = 0; m_timeout = 0; m_refresh = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, registers at reset values
		dir.push_back('{ACT_NEXT, 48'd5, 7'd0, 48'd0, 24'd0, 5'd0, 1, ST_EMPTY, 5'd0});
		dir.push_back('{ACT_LIST, 48'd5, 7'd0, 48'd0, 24'd0, 5'd16, 1, ST_EMPTY, 5'd0});
		dir.push_back('{ACT_RANGED, 48'd5, 7'd9, 48'd1, 24'd1, 5'd0, 1, ST_NOT_FOUND, 5'd0});
		dir.push_back('{3'd7, 48'd5, 7'd0, 48'd0, 24'd0, 5'd0, 1, ST_OK, 5'd0});
		dir.push_back('{3'd5, '1, '1, '1, '1, '1, 1, ST_OK, 5'd0});
		for (int i = 0; i < 16; i++)
			dir.push_back('{ACT_SEEN, 48'd100, 7'(i == 15 ? 127 : i), 48'd0, 24'd0, 5'd0,
				1, ST_OK, 5'(i + 1)});
		dir.push_back('{ACT_SEEN, 48'd100, 7'd100, 48'd0, 24'd0, 5'd0, 1, ST_FULL, 5'd16});
		dir.push_back('{ACT_RANGED, 48'd0, 7'd127, '1, '1, 5'd0, 0, 0, 0});
		dir.push_back('{ACT_LIST, 48'd0, 7'd0, 48'd0, 24'd0, 5'd15, 1, ST_LIMIT, 5'd16});
		dir.push_back('{ACT_LIST, 48'd0, 7'd0, 48'd0, 24'd0, 5'd31, 0, 0, 0});
		dir.push_back('{ACT_NEXT, 48'd0, 7'd0, 48'd0, 24'd0, 5'd0, 0, 0, 0});
		dir.push_back('{ACT_SWEEP, '1, 7'd0, 48'd0, 24'd0, 5'd0, 1, ST_OK, 5'd0});
		foreach (dir[i]) send_action(dir[i]);
		drain();

		// random phases over register settings and idle profiles
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 77; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 77; end
				default: begin send_idle = 15; recv_stall = 15; end
			endcase
			case (ph)
				0: begin write_reg(REG_TIMEOUT, '1); write_reg(REG_REFRESH, '0); end
				1: begin write_reg(REG_TIMEOUT, 48'd0); write_reg(REG_REFRESH, '1); end
				default: begin
					write_reg(REG_TIMEOUT, $urandom_range(3) == 0
						? 48'({$urandom(), $urandom()}) : 48'($urandom_range(1 << 20)));
					write_reg(REG_REFRESH, $urandom_range(3) == 0
						? 48'({$urandom(), $urandom()}) : 48'($urandom_range(2000)));
				end
			endcase
			if (ph == 2) hold_off = 400;
			for (int k = 0; k < 43; k++) begin
				r = rnd_row(ph % 2 ? 128 : 24);
				send_action(r);
			end
			if (ph == 5) begin
				send_idle = 0;
				s_axis_tvalid <= 1'b0;
				while (pending_beats.size() != 0) @(posedge clk);
			end
			drain();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

>>> sim.f
design/ntars_pkg.sv
design/neighbor_table_aging_ranging_select.sv
tb/testbench.sv
